// File: rtl/fpst_pkg.sv
// Package for the Fenwick prefix-sum table: widths, codes, state type and control struct.
package fpst_pkg;

    localparam int MAX_POSITIONS_DEF = 1024;
    localparam int POS_W             = 11;
    localparam int SIZE_W            = 11;
    localparam int DATA_W            = 32;
    // The upward walk can reach one past the largest 11-bit position.
    localparam int WALK_W            = POS_W + 1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } fpst_state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } fpst_mem_ctrl_t;

endpackage

// File: rtl/fenwick_prefix_sum_table.sv
// Busy stays high from the acceptance of an item through the walk and drain states.
// A query result is strobed on done from a register loaded in the drain state; the next start
// can be taken in that same cycle, so items do not overlap (a walk has at most 11 steps for 1024 positions).
// The cell memory port does one read per cycle; write-back happens in the cycle after the read.
// After reset the table clears one cell per cycle, from the first cell to the last, with busy high.
// Configuration writes are taken at any time; the result receiver cannot stall.
module fenwick_prefix_sum_table #(
    parameter int MAX_POSITIONS = fpst_pkg::MAX_POSITIONS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                op,
    input  logic [fpst_pkg::POS_W-1:0]          position,
    input  logic signed [fpst_pkg::DATA_W-1:0]  delta,
    input  logic                                cfg_wr_en,
    input  logic [fpst_pkg::SIZE_W-1:0]         cfg_wr_data,
    output logic                                done,
    output logic signed [fpst_pkg::DATA_W-1:0]  prefix_sum
);
    import fpst_pkg::*;

    localparam int AW = $clog2(MAX_POSITIONS);

    fpst_mem_ctrl_t    mem_ctrl;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] rd_data;

    fpst_ctrl #(
        .MAX_POSITIONS (MAX_POSITIONS),
        .AW            (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .op          (op),
        .position    (position),
        .delta       (delta),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .busy        (busy),
        .done        (done),
        .prefix_sum  (prefix_sum),
        .mem_ctrl    (mem_ctrl),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_data     (rd_data)
    );

    fpst_cell_ram #(
        .MAX_POSITIONS (MAX_POSITIONS),
        .AW            (AW)
    ) u_ram (
        .clk      (clk),
        .mem_ctrl (mem_ctrl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_data  (rd_data)
    );

endmodule

// File: rtl/fpst_cell_ram.sv
// Cell memory of the table: one write port and one registered read port.
module fpst_cell_ram #(
    parameter int MAX_POSITIONS = fpst_pkg::MAX_POSITIONS_DEF,
    parameter int AW            = $clog2(MAX_POSITIONS)
) (
    input  logic                         clk,
    input  fpst_pkg::fpst_mem_ctrl_t     mem_ctrl,
    input  logic [AW-1:0]                rd_addr,
    input  logic [AW-1:0]                wr_addr,
    input  logic [fpst_pkg::DATA_W-1:0]  wr_data,
    output logic [fpst_pkg::DATA_W-1:0]  rd_data
);
    import fpst_pkg::*;

    logic [DATA_W-1:0] mem [MAX_POSITIONS];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_ctrl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/fpst_ctrl.sv
// Walk sequencer: clearing pass, upward add walk, downward query walk and write-back.
module fpst_ctrl #(
    parameter int MAX_POSITIONS = fpst_pkg::MAX_POSITIONS_DEF,
    parameter int AW            = $clog2(MAX_POSITIONS)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                op,
    input  logic [fpst_pkg::POS_W-1:0]          position,
    input  logic signed [fpst_pkg::DATA_W-1:0]  delta,
    input  logic                                cfg_wr_en,
    input  logic [fpst_pkg::SIZE_W-1:0]         cfg_wr_data,
    output logic                                busy,
    output logic                                done,
    output logic signed [fpst_pkg::DATA_W-1:0]  prefix_sum,
    output fpst_pkg::fpst_mem_ctrl_t            mem_ctrl,
    output logic [AW-1:0]                       rd_addr,
    output logic [AW-1:0]                       wr_addr,
    output logic [fpst_pkg::DATA_W-1:0]         wr_data,
    input  logic [fpst_pkg::DATA_W-1:0]         rd_data
);
    import fpst_pkg::*;

    localparam int LIM_W = $clog2(MAX_POSITIONS + 1);
    localparam int CW    = (LIM_W > WALK_W) ? LIM_W : WALK_W;
    localparam logic [CW-1:0] MAX_C    = CW'(MAX_POSITIONS);
    localparam logic [AW-1:0] CLR_LAST = AW'(MAX_POSITIONS - 1);

    fpst_state_t state_reg, state_next;

    logic [SIZE_W-1:0] size_reg;
    logic [WALK_W-1:0] p_reg, p_next;
    logic              op_reg, op_next;
    logic [DATA_W-1:0] delta_reg, delta_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic              done_reg, done_next;
    logic [DATA_W-1:0] sum_reg, sum_next;

    logic [WALK_W-1:0] low_bit;
    logic [CW-1:0]     p_ext;
    logic [CW-1:0]     size_ext;
    logic [CW-1:0]     lim_ext;
    logic [CW-1:0]     cell_addr_ext;
    logic              walk_stop;
    logic              cell_in_table;
    logic              clr_last;

    assign low_bit       = p_reg & (~p_reg + WALK_W'(1));
    assign p_ext         = CW'(p_reg);
    assign size_ext      = CW'(size_reg);
    assign lim_ext       = (size_ext > MAX_C) ? MAX_C : size_ext;
    assign cell_addr_ext = p_ext - CW'(1);
    assign cell_in_table = (p_ext <= MAX_C);
    assign walk_stop     = (p_reg == '0) || ((op_reg == OP_ADD) && (p_ext > lim_ext));
    assign clr_last      = (clr_addr_reg == CLR_LAST);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_stop)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath next values.
    always_comb
    begin
        mem_ctrl        = '0;
        rd_addr         = cell_addr_ext[AW-1:0];
        wr_addr         = pend_addr_reg;
        wr_data         = rd_data + delta_reg;
        p_next          = p_reg;
        op_next         = op_reg;
        delta_next      = delta_reg;
        acc_next        = acc_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = cell_addr_ext[AW-1:0];
        clr_addr_next   = clr_addr_reg;
        done_next       = 1'b0;
        sum_next        = sum_reg;

        // The cell read in the previous cycle is written back or summed now.
        if (pend_valid_reg)
        begin
            if (op_reg == OP_ADD)
            begin
                mem_ctrl.wr_en = 1'b1;
            end
            else
            begin
                acc_next = acc_reg + rd_data;
            end
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_ctrl.wr_en = 1'b1;
                wr_addr        = clr_addr_reg;
                wr_data        = '0;
                clr_addr_next  = clr_addr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    p_next     = WALK_W'(position);
                    op_next    = op;
                    delta_next = $unsigned(delta);
                    acc_next   = '0;
                end
            end
            ST_WALK:
            begin
                if (!walk_stop)
                begin
                    // Query cells beyond the table count as zero and are not read.
                    mem_ctrl.rd_en  = (op_reg == OP_ADD) || cell_in_table;
                    pend_valid_next = mem_ctrl.rd_en;
                    if (op_reg == OP_ADD)
                    begin
                        p_next = p_reg + low_bit;
                    end
                    else
                    begin
                        p_next = p_reg - low_bit;
                    end
                end
            end
            ST_DRAIN:
            begin
                done_next = (op_reg == OP_QUERY);
                sum_next  = acc_next;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            size_reg       <= SIZE_RESET;
            pend_valid_reg <= 1'b0;
            clr_addr_reg   <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            clr_addr_reg   <= clr_addr_next;
            done_reg       <= done_next;
            if (cfg_wr_en)
            begin
                size_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg         <= p_next;
        op_reg        <= op_next;
        delta_reg     <= delta_next;
        acc_reg       <= acc_next;
        pend_addr_reg <= pend_addr_next;
        sum_reg       <= sum_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign prefix_sum = $signed(sum_reg);

endmodule

// File: rtl/fpst_checker.sv
// Port-level checks of the table's command and result timing, bound to the top level.
module fpst_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // A result only appears once the walk that made it has finished.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done strobed while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a preceding walk");

    // Each result is a one-cycle strobe.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // An accepted transaction must occupy the block in the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

endmodule

bind fenwick_prefix_sum_table fpst_checker u_fpst_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

// File: tb/testbench.sv
// Self-checking testbench for the Fenwick prefix-sum table: adds, prefix queries, size settings.
`timescale 1ns / 1ps

module testbench;

    import fpst_pkg::*;

    localparam int MAX_POSITIONS = fpst_pkg::MAX_POSITIONS_DEF;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 4000;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     start       = 1'b0;
    logic                     op          = OP_ADD;
    logic [POS_W-1:0]         position    = '0;
    logic signed [DATA_W-1:0] delta       = '0;
    logic                     cfg_wr_en   = 1'b0;
    logic [SIZE_W-1:0]        cfg_wr_data = '0;
    logic                     busy;
    logic                     done;
    logic signed [DATA_W-1:0] prefix_sum;

    // Predictor state: its own copy of the cells and of the size register.
    logic [DATA_W-1:0] cell_model [1:MAX_POSITIONS];
    logic [SIZE_W-1:0] size_model;

    logic [DATA_W-1:0] expected_sums [$];
    logic [DATA_W-1:0] popped_sum;

    int mismatch_count  = 0;
    int adds_sent       = 0;
    int queries_sent    = 0;
    int results_checked = 0;
    int size_writes     = 0;

    fenwick_prefix_sum_table #(
        .MAX_POSITIONS(MAX_POSITIONS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .position   (position),
        .delta      (delta),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .done       (done),
        .prefix_sum (prefix_sum)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic int effective_size();
        return (int'(size_model) > MAX_POSITIONS) ? MAX_POSITIONS : int'(size_model);
    endfunction

    // Upward walk: lowest set bit added each step, stopping beyond the size in use.
    function automatic void apply_add(input logic [POS_W-1:0] pos, input logic [DATA_W-1:0] d);
        logic [WALK_W-1:0] p;
        int                lim;
        p   = {1'b0, pos};
        lim = effective_size();
        while (p != '0 && int'(p) <= lim)
        begin
            cell_model[p] = cell_model[p] + d;
            p = p + (p & (~p + WALK_W'(1)));
        end
    endfunction

    // Downward walk: lowest set bit cleared each step; cells past the table count as zero.
    function automatic logic [DATA_W-1:0] predict_prefix(input logic [POS_W-1:0] pos);
        logic [WALK_W-1:0] p;
        logic [DATA_W-1:0] acc;
        p   = {1'b0, pos};
        acc = '0;
        while (p != '0)
        begin
            if (int'(p) <= MAX_POSITIONS)
                acc = acc + cell_model[p];
            p = p - (p & (~p + WALK_W'(1)));
        end
        return acc;
    endfunction

    // Entered in the time step of a rising edge; returns in the step of the accepting edge.
    task automatic send_item(input logic item_op, input logic [POS_W-1:0] pos,
                             input logic [DATA_W-1:0] d);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op       <= item_op;
        position <= pos;
        delta    <= d;
        start    <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (item_op == OP_QUERY)
        begin
            expected_sums.insert(expected_sums.size(), predict_prefix(pos));
            queries_sent++;
        end
        else
        begin
            apply_add(pos, d);
            adds_sent++;
        end
    endtask

    // Adds give no result, so after the last query the block may still be walking.
    task automatic wait_idle();
        int cycles;
        cycles = 0;
        start <= 1'b0;
        while (expected_sums.size() != 0 && cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy && cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
    endtask

    task automatic set_size(input logic [SIZE_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        size_model  = value;
        size_writes++;
    endtask

    task automatic test_position_zero();
        send_item(OP_ADD, 11'd0, 32'h1234_5678);
        send_item(OP_QUERY, 11'd0, 32'hFFFF_FFFF);
        send_item(OP_QUERY, 11'd1, 32'h0);
    endtask

    task automatic test_field_extremes();
        send_item(OP_ADD, 11'd1, 32'h7FFF_FFFF);
        send_item(OP_ADD, 11'd1, 32'h0000_0001);
        send_item(OP_ADD, 11'd1024, 32'h8000_0000);
        send_item(OP_ADD, 11'd1023, 32'hFFFF_FFFF);
        send_item(OP_QUERY, 11'd1, 32'h0);
        send_item(OP_QUERY, 11'd1023, 32'h0);
        send_item(OP_QUERY, 11'd1024, 32'h0);
        // Positions past the table: adds are dropped, queries skip the missing cells.
        send_item(OP_ADD, 11'd1025, 32'h0000_0100);
        send_item(OP_ADD, 11'd2047, 32'h5555_AAAA);
        send_item(OP_QUERY, 11'd1536, 32'h0);
        send_item(OP_QUERY, 11'd2047, 32'h0);
    endtask

    task automatic test_size_limits();
        set_size(11'd1);
        send_item(OP_ADD, 11'd2, 32'h0000_0040);
        send_item(OP_ADD, 11'd1, 32'hFFFF_FFF0);
        // Cells above the size are still read as stored.
        send_item(OP_QUERY, 11'd1024, 32'h0);
        set_size(11'd0);
        send_item(OP_ADD, 11'd1, 32'h0000_0777);
        send_item(OP_QUERY, 11'd1, 32'h0);
        set_size(11'd2047);
        send_item(OP_ADD, 11'd1000, 32'h0001_0000);
        send_item(OP_QUERY, 11'd1024, 32'h0);
        set_size(11'd1024);
        send_item(OP_ADD, 11'd512, 32'h0000_0003);
        send_item(OP_QUERY, 11'd600, 32'h0);
    endtask

    task automatic test_random_traffic();
        logic [SIZE_W-1:0] phase_size;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] d;
        logic              item_op;
        int                lim;
        int                pick;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: phase_size = 11'd1024;
                1: phase_size = SIZE_W'($urandom_range(1, 31));
                2: phase_size = SIZE_W'($urandom_range(32, 1023));
                3: phase_size = SIZE_W'($urandom_range(1025, 2047));
                default: phase_size = SIZE_W'($urandom_range(1, 1024));
            endcase
            set_size(phase_size);
            lim = (effective_size() == 0) ? MAX_POSITIONS : effective_size();
            for (int i = 0; i < 90; i++)
            begin
                item_op = ($urandom_range(0, 99) < 55) ? OP_ADD : OP_QUERY;
                pick    = $urandom_range(0, 9);
                if (pick == 0)
                    pos = '0;
                else if (pick == 1)
                    pos = POS_W'($urandom_range(0, 2047));
                else
                    pos = POS_W'($urandom_range(1, lim));
                if ($urandom_range(0, 9) < 7)
                    d = $urandom;
                else
                    d = DATA_W'($urandom_range(0, 200)) - 32'd100;
                send_item(item_op, pos, d);
            end
        end
    endtask

    // Results cannot be held off, so each strobe is a completed transaction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_sums.size() == 0)
                report_mismatch($sformatf("unexpected result prefix_sum=%0d", prefix_sum));
            else
            begin
                popped_sum = expected_sums.pop_front();
                if (prefix_sum !== popped_sum)
                    report_mismatch($sformatf("prefix_sum got %0d expected %0d",
                                              prefix_sum, $signed(popped_sum)));
                results_checked++;
            end
        end
    end

    initial
    begin
        for (int i = 1; i <= MAX_POSITIONS; i++)
            cell_model[i] = '0;
        size_model = SIZE_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_position_zero();
        test_field_extremes();
        test_size_limits();
        test_random_traffic();
        wait_idle();
        if (expected_sums.size() != 0)
            report_mismatch($sformatf("%0d query results never arrived", expected_sums.size()));
        $display("summary: %0d adds and %0d queries sent, %0d sums compared",
                 adds_sent, queries_sent, results_checked);
        $display("summary: %0d size settings including 0, 1, 1024 and above the table",
                 size_writes);
        if (mismatch_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial
    begin
        #500000;
        $display("timeout: run did not complete");
        $display("testbench: errors");
        $finish;
    end

endmodule
